// ===== hw/rtl/gradient_edge_magnitude_core_macros.svh =====
// Assertion macros shared by the edge magnitude RTL.
`ifndef GRADIENT_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define GRADIENT_EDGE_MAGNITUDE_CORE_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define GEM_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check a consequence in the cycle after its condition.
`define GEM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/gem_pkg.sv =====
// Types and constants shared by the edge magnitude modules.
package gem_pkg;

  localparam int PIX_W       = 8;
  localparam int REG_W       = 11;
  localparam int GRAD_W      = 9;
  localparam int SQ_W        = 16;
  localparam int SUM_W       = 17;
  localparam int RAD_W       = 18;
  localparam int REM_W       = 12;
  localparam int ROOT_W      = 9;
  localparam int SQRT_STEPS  = 9;
  localparam int PROD_W      = 24;

  localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;

  // Gray weights 0.21, 0.71, 0.07 in unsigned Q0.16
  localparam logic [15:0] COEF_RED   = 16'd13763;
  localparam logic [15:0] COEF_GREEN = 16'd46531;
  localparam logic [15:0] COEF_BLUE  = 16'd4588;

  localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } gem_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             drain;
  } gem_pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             last_of_frame;
  } gem_result_t;

  // Result attributes that ride alongside the magnitude datapath
  typedef struct packed {
    logic             border;
    logic             last;
    logic [PIX_W-1:0] center;
  } gem_side_t;

  typedef struct packed {
    logic                     valid;
    gem_side_t                side;
    logic signed [GRAD_W-1:0] g1;
    logic signed [GRAD_W-1:0] g2;
  } gem_grad_t;

  typedef struct packed {
    logic              valid;
    gem_side_t         side;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } gem_cell_t;

endpackage

// ===== hw/rtl/gradient_edge_magnitude_core.sv =====
// Top level of the edge magnitude block: squaring, root chain and output register.
//
// Use: pixels enter in raster order on in_valid/in_stall/in_data; one result per
// request leaves on out_valid/out_stall/out_data, one row behind the input.
// Pixels of the first row give no result. After the frame, send image_width
// requests (any payload) to flush the last row; its final result carries
// last_of_frame. A drain request arriving inside the frame is dropped.
// Flow: a new request is taken only after the previous one has written back. Each
// request reads both line buffers in its accept cycle and writes them back in its
// write state, which a stall can hold; the input holds stall during that state.
// Path: after acceptance a result passes the gradient, square, sum, 9 root cells
// and output register on its way to out_data.
// Stall: while out_valid is high and out_stall holds, the whole result pipeline
// freezes and a request caught in its write cycle keeps in_stall high.
// Reset: counters, neighbor registers and registers go to their reset values
// (640 x 480); line buffers are not cleared and need no reset pass.
// Config: cfg_write/cfg_index/cfg_data; user writes only while idle; not enforced.
`include "gradient_edge_magnitude_core_macros.svh"

module gradient_edge_magnitude_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gem_pkg::gem_pixel_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gem_pkg::gem_result_t out_data,
  input  logic                 cfg_write,
  input  gem_pkg::gem_reg_t    cfg_index,
  input  logic [10:0]          cfg_data
);
  import gem_pkg::*;

  logic                      advance;
  gem_grad_t                 grad;
  logic signed [2*GRAD_W-1:0] sq1_full;
  logic signed [2*GRAD_W-1:0] sq2_full;

  logic              sq_valid;
  gem_side_t         sq_side;
  logic [SQ_W-1:0]   sq1;
  logic [SQ_W-1:0]   sq2;
  logic              sum_valid;
  gem_side_t         sum_side;
  logic [SUM_W-1:0]  sum;
  gem_cell_t         chain [SQRT_STEPS+1];
  gem_cell_t         last_cell;

  // Whole result pipeline moves unless a finished result is held
  assign advance = !out_valid || !out_stall;

  gem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .advance  (advance),
    .grad     (grad)
  );

  // Square the two gradients, then add
  assign sq1_full = grad.g1 * grad.g1;
  assign sq2_full = grad.g2 * grad.g2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else if (advance) begin
      sq_valid  <= grad.valid;
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_side  <= grad.side;
      sq1      <= sq1_full[SQ_W-1:0];
      sq2      <= sq2_full[SQ_W-1:0];
      sum_side <= sq_side;
      sum      <= SUM_W'(sq1) + SUM_W'(sq2);
    end
  end

  // Root chain: one result bit per cell
  assign chain[0].valid = sum_valid;
  assign chain[0].side  = sum_side;
  assign chain[0].rad   = RAD_W'(sum);
  assign chain[0].rem   = '0;
  assign chain[0].root  = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
    gem_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  assign last_cell = chain[SQRT_STEPS];

  // Output register: border pixels pass their gray value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last_cell.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.last_of_frame <= last_cell.side.last;
      if (last_cell.side.border) begin
        out_data.level <= last_cell.side.center;
      end else if (last_cell.root > ROOT_W'(LEVEL_MAX)) begin
        out_data.level <= LEVEL_MAX;
      end else begin
        out_data.level <= last_cell.root[PIX_W-1:0];
      end
    end
  end

  `GEM_ASSERT_NEXT(a_hold_sum, !advance,
                   $stable(sum_valid) && $stable(sq_valid), "pipeline moved while held")
  `GEM_ASSERT_NEXT(a_sum_enters, advance && sum_valid, chain[1].valid,
                   "sum lost entering root chain")
  `GEM_ASSERT_SAME(a_grad_moves, grad.valid, advance, "gradient issued while pipeline held")

endmodule

// ===== hw/rtl/gem_front.sv =====
// Pixel front end: gray conversion, line buffers, counters and gradients.
`include "gradient_edge_magnitude_core_macros.svh"

module gem_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gem_pkg::gem_pixel_t  in_data,
  input  logic                 cfg_write,
  input  gem_pkg::gem_reg_t    cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 advance,
  output gem_pkg::gem_grad_t   grad
);
  import gem_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;

  typedef enum logic {
    ST_IDLE,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_PIXEL,
    OP_DRAIN
  } op_t;

  state_t state;
  op_t    op;

  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [AW-1:0]    column_count;
  logic [REG_W-1:0] row_count;
  logic             produce;
  logic             border;
  logic             last;
  logic [AW-1:0]    addr;

  logic [PIX_W-1:0] older_line [MAX_WIDTH];
  logic [PIX_W-1:0] recent_line [MAX_WIDTH];
  logic [PIX_W-1:0] older_rd;
  logic [PIX_W-1:0] recent_rd;
  logic [PIX_W-1:0] previous_gray;
  logic [PIX_W-1:0] previous_older_gray;

  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_blue;

  logic [WW-1:0]     eff_width;
  logic [REG_W-1:0]  eff_height;
  logic [WW-1:0]     col_plus;
  logic              row_end;
  logic              drain_row;
  logic              accept;
  logic              finish;
  logic [PROD_W:0]   gray_sum;
  logic [GRAD_W-1:0] gray_wide;
  logic [PIX_W-1:0]  gray;

  // Effective frame size: zero acts as one, width limited to the buffer depth
  always_comb begin
    if (image_width == '0) begin
      eff_width = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    eff_height = (image_height == '0) ? REG_W'(1) : image_height;
  end

  assign col_plus  = WW'(column_count) + WW'(1);
  assign row_end   = col_plus >= eff_width;
  assign drain_row = row_count >= eff_height;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && (state == ST_IDLE);
  assign finish    = (state == ST_WRITE) && advance;

  // Gray value from the registered weighted products
  assign gray_sum  = (PROD_W+1)'(prod_red) + (PROD_W+1)'(prod_green)
                   + (PROD_W+1)'(prod_blue);
  assign gray_wide = gray_sum[PROD_W:16];
  assign gray      = (gray_wide > GRAD_W'(LEVEL_MAX)) ? LEVEL_MAX : gray_wide[PIX_W-1:0];

  // Control sequencer, counters and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_IGNORE;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_WRITE;
            if (drain_row) begin
              op <= OP_DRAIN;
            end else if (in_data.drain) begin
              op <= OP_IGNORE;
            end else begin
              op <= OP_PIXEL;
            end
            // Advance position unless the request is a stray drain item
            if (drain_row || !in_data.drain) begin
              if (row_end) begin
                column_count <= '0;
                row_count    <= drain_row ? '0 : row_count + REG_W'(1);
              end else begin
                column_count <= column_count + AW'(1);
              end
            end
          end
        end
        ST_WRITE: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Per-request attributes and line buffer reads, taken at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      addr       <= column_count;
      last       <= drain_row && row_end;
      produce    <= drain_row || (!in_data.drain && row_count != '0);
      border     <= drain_row || column_count == '0 || row_end
                    || row_count == REG_W'(1);
      prod_red   <= PROD_W'(in_data.red) * PROD_W'(COEF_RED);
      prod_green <= PROD_W'(in_data.green) * PROD_W'(COEF_GREEN);
      prod_blue  <= PROD_W'(in_data.blue) * PROD_W'(COEF_BLUE);
      older_rd   <= older_line[column_count];
      recent_rd  <= recent_line[column_count];
    end
  end

  // Shift the column down the line buffers and keep the left neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_gray       <= '0;
      previous_older_gray <= '0;
    end else if (finish && op == OP_PIXEL) begin
      previous_gray       <= gray;
      previous_older_gray <= older_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && op == OP_PIXEL) begin
      older_line[addr]  <= recent_rd;
      recent_line[addr] <= gray;
    end
  end

  // Gradients against the lower-left and upper-left neighbors
  always_comb begin
    grad.valid       = finish && produce;
    grad.side.border = border;
    grad.side.last   = last;
    grad.side.center = recent_rd;
    grad.g1 = $signed({1'b0, recent_rd}) - $signed({1'b0, previous_gray});
    grad.g2 = $signed({1'b0, recent_rd}) - $signed({1'b0, previous_older_gray});
  end

  `GEM_ASSERT_NEXT(a_accept_busy, accept, state == ST_WRITE, "accepted request not in write phase")
  `GEM_ASSERT_NEXT(a_hold_write, state == ST_WRITE && !advance,
                   state == ST_WRITE && $stable(addr) && $stable(op), "write phase lost while held")
  `GEM_ASSERT_SAME(a_no_result_ignored, grad.valid, op != OP_IGNORE, "ignored request produced a result")

endmodule

// ===== hw/rtl/gem_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module gem_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  gem_pkg::gem_cell_t cell_in,
  output gem_pkg::gem_cell_t cell_out
);
  import gem_pkg::*;

  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring in the next two radicand bits and try the next root digit
  assign rem_shift = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
  assign trial     = {1'b0, cell_in.root, 2'b01};
  assign fits      = rem_shift >= trial;

  // Hand the partial root to the next cell; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out.valid <= cell_in.valid;
    end
    if (advance) begin
      cell_out.side <= cell_in.side;
      cell_out.rad  <= cell_in.rad << 2;
      cell_out.rem  <= fits ? rem_shift - trial : rem_shift;
      cell_out.root <= {cell_in.root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== verif/tb_gradient_edge_magnitude_core.sv =====
// Self-checking testbench for the edge magnitude core against a gray/gradient predictor.
module tb_gradient_edge_magnitude_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gem_pkg::*;

  localparam int unsigned MAX_W          = 1024;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned END_WAIT       = 40;
  localparam int unsigned STUCK_LIMIT    = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned BACKLOG_AT     = 400;
  localparam int unsigned BACKLOG_CYCLES = 300;

  // Gray weights in unsigned Q0.16
  localparam int unsigned WEIGHT_RED   = 13763;
  localparam int unsigned WEIGHT_GREEN = 46531;
  localparam int unsigned WEIGHT_BLUE  = 4588;

  localparam logic [23:0] INK_BLACK = 24'h000000;
  localparam logic [23:0] INK_WHITE = 24'hFFFFFF;
  localparam logic [23:0] INK_RED   = 24'hFF0000;
  localparam logic [23:0] INK_GREEN = 24'h00FF00;
  localparam logic [23:0] INK_BLUE  = 24'h0000FF;
  localparam logic [23:0] INK_BROWN = 24'h804020;

  typedef struct {
    bit          reg_write;
    gem_reg_t    reg_sel;
    logic [10:0] reg_value;
    gem_pixel_t  pixel;
    int unsigned gap;
  } feed_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gem_pixel_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gem_result_t out_data;
  logic        cfg_write = 1'b0;
  gem_reg_t    cfg_index = REG_IMAGE_WIDTH;
  logic [10:0] cfg_data = '0;

  feed_entry_t pixel_feed[$];
  gem_result_t pending_levels[$];
  int unsigned fed_items = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_wait = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned stuck_cycles = 0;
  bit          backlog_done = 1'b0;

  // Predictor state
  logic [10:0] width_reg = 11'd640;
  logic [10:0] height_reg = 11'd480;
  logic [7:0]  older_row[MAX_W];
  logic [7:0]  recent_row[MAX_W];
  logic [7:0]  left_gray = '0;
  logic [7:0]  left_older_gray = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  gradient_edge_magnitude_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] gray_of(gem_pixel_t p);
    int unsigned acc;
    acc = (WEIGHT_RED * p.red + WEIGHT_GREEN * p.green + WEIGHT_BLUE * p.blue) >> 16;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic int unsigned root_floor(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 9; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Advance the predictor by one accepted request and queue the level it causes
  function automatic void predict_edge_level(gem_pixel_t p);
    int unsigned w, h, c, idx, center, lvl, sum;
    int          g1, g2;
    logic [7:0]  gray;
    bit          row_end;
    gem_result_t r;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    c = col_pos;
    idx = (c < MAX_W) ? c : MAX_W - 1;
    row_end = (c + 1 >= w);
    // Flush row: every request emits the last frame row as border
    if (row_pos >= h) begin
      r.level = recent_row[idx];
      r.last_of_frame = row_end;
      pending_levels.push_back(r);
      if (row_end) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
      return;
    end
    // Drop flush requests inside the frame
    if (p.drain) return;
    gray = gray_of(p);
    if (row_pos != 0) begin
      center = recent_row[idx];
      // Output row is row_pos-1; its bottom neighbor is always inside the frame here
      if (c == 0 || row_end || row_pos == 1) begin
        lvl = center;
      end else begin
        g1 = int'(center) - int'(left_gray);
        g2 = int'(center) - int'(left_older_gray);
        sum = g1 * g1 + g2 * g2;
        lvl = root_floor(sum);
        if (lvl > 255) lvl = 255;
      end
      r.level = lvl[7:0];
      r.last_of_frame = 1'b0;
      pending_levels.push_back(r);
    end
    left_older_gray = older_row[idx];
    older_row[idx] = recent_row[idx];
    recent_row[idx] = gray;
    left_gray = gray;
    if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic feed_pixel(logic [23:0] rgb, bit drain, bit calm);
    feed_entry_t e;
    e.reg_write = 1'b0;
    e.reg_sel = REG_IMAGE_WIDTH;
    e.reg_value = '0;
    e.pixel.red = rgb[23:16];
    e.pixel.green = rgb[15:8];
    e.pixel.blue = rgb[7:0];
    e.pixel.drain = drain;
    e.gap = calm ? 0 : $urandom_range(0, 12);
    pixel_feed.push_back(e);
  endtask

  task automatic feed_reg(gem_reg_t sel, logic [10:0] value);
    feed_entry_t e;
    e.reg_write = 1'b1;
    e.reg_sel = sel;
    e.reg_value = value;
    e.pixel = '0;
    e.gap = 0;
    pixel_feed.push_back(e);
  endtask

  // One full frame plus its flush row, with a little noise when not calm
  task automatic feed_frame(logic [10:0] w_reg, logic [10:0] h_reg, bit calm);
    int unsigned w, h, base;
    int          v;
    bit          narrow;
    logic [23:0] rgb;
    feed_reg(REG_IMAGE_WIDTH, w_reg);
    feed_reg(REG_IMAGE_HEIGHT, h_reg);
    w = (w_reg == 0) ? 1 : (w_reg > MAX_W) ? MAX_W : w_reg;
    h = (h_reg == 0) ? 1 : h_reg;
    narrow = 1'($urandom_range(0, 1));
    base = $urandom_range(0, 255);
    for (int i = 0; i < w * h; i++) begin
      if (!calm && $urandom_range(0, 19) == 0) feed_pixel(24'($urandom), 1'b1, calm);
      rgb = 24'($urandom);
      if (narrow) begin
        for (int k = 0; k < 3; k++) begin
          v = int'(base) + int'($urandom_range(0, 40)) - 20;
          rgb[k*8 +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
        end
      end
      feed_pixel(rgb, 1'b0, calm);
    end
    for (int i = 0; i < w; i++) begin
      feed_pixel(24'($urandom), ($urandom_range(0, 2) != 0), calm);
    end
    fed_items += w * h + w;
  endtask

  // Drive requests and register writes from the feed queue
  always @(posedge clk) begin : drive_requests
    feed_entry_t head;
    logic        next_valid;
    logic        next_write;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
      send_wait <= 0;
    end else begin
      next_valid = in_valid && in_stall;
      next_write = 1'b0;
      if (!next_valid) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
        end else if (pixel_feed.size() != 0) begin
          head = pixel_feed[0];
          if (!head.reg_write) begin
            next_valid = 1'b1;
            in_data <= head.pixel;
            send_wait <= head.gap;
            void'(pixel_feed.pop_front());
          end else if (quiet_cycles >= SETTLE_CYCLES) begin
            // Write registers only once the block has gone quiet
            next_write = 1'b1;
            cfg_index <= head.reg_sel;
            cfg_data <= head.reg_value;
            void'(pixel_feed.pop_front());
          end
        end
      end
      in_valid <= next_valid;
      cfg_write <= next_write;
    end
  end

  // Pace the result side; hold off once for a long stretch to back up the pipe
  always @(posedge clk) begin : pace_results
    int unsigned next_hold;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      results_seen <= 0;
    end else begin
      next_hold = (hold_left != 0) ? hold_left - 1 : 0;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (!backlog_done && results_seen >= BACKLOG_AT && !out_data.last_of_frame) begin
          next_hold = BACKLOG_CYCLES;
          backlog_done <= 1'b1;
        end else if (results_seen % 200 < 50) begin
          next_hold = 0;
        end else begin
          next_hold = $urandom_range(0, 12);
        end
      end
      hold_left <= next_hold;
      out_stall <= (next_hold != 0);
    end
  end

  // Check results, track register writes and predict accepted requests
  always @(posedge clk) begin : check_results
    gem_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          $error("result with nothing expected: level %0d last_of_frame %0d",
                 out_data.level, out_data.last_of_frame);
          fail_count++;
        end else begin
          want = pending_levels.pop_front();
          if (out_data.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, out_data.level);
            fail_count++;
          end
          if (out_data.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0d, got %0d",
                   want.last_of_frame, out_data.last_of_frame);
            fail_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_edge_level(in_data);
      if (pending_levels.size() != 0 || (in_valid && !in_stall) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("gradient_edge_magnitude_core regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : run_regression
    int unsigned pick, w, h;
    for (int i = 0; i < MAX_W; i++) begin
      older_row[i] = '0;
      recent_row[i] = '0;
    end

    // 4x4 test card: saturated gradients both ways, a mid-range one and a flat one
    feed_reg(REG_IMAGE_WIDTH, 11'd4);
    feed_reg(REG_IMAGE_HEIGHT, 11'd4);
    feed_pixel(INK_BLACK, 1'b1, 1'b0);
    feed_pixel(INK_BLACK, 1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_BLACK, 1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_RED,   1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b1, 1'b0);
    feed_pixel(INK_BLACK, 1'b0, 1'b0);
    feed_pixel(INK_GREEN, 1'b0, 1'b0);
    feed_pixel(INK_BLACK, 1'b0, 1'b0);
    feed_pixel(INK_BROWN, 1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_BLUE,  1'b0, 1'b0);
    feed_pixel(INK_BLUE,  1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_BLACK, 1'b0, 1'b0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    // Flush row: pixels here act as flush requests
    feed_pixel(INK_WHITE, 1'b1, 1'b0);
    feed_pixel(INK_RED,   1'b0, 1'b0);
    feed_pixel(INK_BLACK, 1'b1, 1'b0);
    feed_pixel(INK_GREEN, 1'b0, 1'b0);

    // Zero width and height act as a single pixel
    feed_reg(REG_IMAGE_WIDTH, 11'd0);
    feed_reg(REG_IMAGE_HEIGHT, 11'd0);
    feed_pixel(INK_WHITE, 1'b0, 1'b0);
    feed_pixel(INK_BLUE, 1'b0, 1'b0);

    // Tallest frame, one pixel wide
    feed_frame(11'd1, 11'd1024, 1'b1);

    // Random frames, mostly small
    while (fed_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) w = $urandom_range(1, 12);
      else if (pick < 19) w = $urandom_range(13, 48);
      else w = $urandom_range(49, 128);
      if (w > 48) h = $urandom_range(1, 3);
      else if ($urandom_range(0, 4) == 0) h = $urandom_range(9, 24);
      else h = $urandom_range(1, 8);
      feed_frame(11'(w), 11'(h), ($urandom_range(0, 3) == 0));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pixel_feed.size() != 0 || in_valid) @(negedge clk);
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("gradient_edge_magnitude_core regression: pass");
    end else begin
      $display("gradient_edge_magnitude_core regression: fail");
    end
    $finish;
  end

endmodule
